/* sv/e2q_pkg.sv */
package e2q_pkg;

    localparam int ANGLE_W = 16;
    localparam int QUAT_W = 16;
    localparam int XW = 32;
    localparam int LANES = 3;

    // lanes: half-sum, half-difference and theta
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_T = 2;

    localparam int ANGLE_FRAC_BITS_DEF = 6;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_CIRCLE_DEG = 180;
    localparam longint QUARTER_DEG = 90;
    localparam longint CORDIC_GAIN_Q30 = 652032874;

    localparam int CORDIC_FRAC = 30;
    localparam int QUAT_FRAC = 15;
    localparam int QUAT_MAX = 32767;
    localparam int QUAT_MIN = -32768;

    localparam int ATAN_ENTRIES = 24;
    localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };

    typedef logic [1:0] quad_t;

    localparam quad_t QUAD_0 = 2'd0;
    localparam quad_t QUAD_1 = 2'd1;
    localparam quad_t QUAD_2 = 2'd2;

    // residual angle is carried scaled by the degree-to-radian divisor
    function automatic int z_width(int frac);
        longint quarter;
        quarter = QUARTER_DEG << (frac + 1);
        return $clog2(quarter * PI_Q30) + 2;
    endfunction

endpackage

/* sv/euler_to_quaternion_top.sv */
// Euler angles (z-x-z) to unit quaternion. Each word carries phi, theta and psi
// in degrees with ANGLE_FRAC_BITS fractional bits; the result word carries w, x,
// y and z in signed Q1.15, rounded and clamped so +1.0 reads 32767. The block is
// fully pipelined and takes one word every cycle while the output is accepted.
// Up to 24 rotation stages take effect. A word passes through angle folding and
// radian scaling, one rotation cell per stage in the chain, then products and
// rounding into the output register.
// Every stage has its own valid bit, so a stalled result does not block input
// until the whole chain has filled.
module euler_to_quaternion_top #(
    parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int ROTATION_STAGES = e2q_pkg::ROTATION_STAGES_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] s_roll_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] s_pitch_deg,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] s_yaw_deg,
    output logic m_valid,
    input  logic m_ready,
    output logic signed [e2q_pkg::QUAT_W-1:0] m_quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0] m_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0] m_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0] m_quat_z
);
    import e2q_pkg::*;

    localparam int ZW = z_width(ANGLE_FRAC_BITS);
    localparam int NS = (ROTATION_STAGES < ATAN_ENTRIES) ? ROTATION_STAGES : ATAN_ENTRIES;

    logic [NS:0] cv;
    logic [NS:0] cr;
    logic signed [XW-1:0] cx [NS+1][LANES];
    logic signed [XW-1:0] cy [NS+1][LANES];
    logic signed [ZW-1:0] cz [NS][LANES];
    quad_t cq [NS+1][LANES];

    e2q_reduce #(
        .FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .phi      (s_roll_deg),
        .theta    (s_pitch_deg),
        .psi      (s_yaw_deg),
        .out_valid(cv[0]),
        .out_ready(cr[0]),
        .z_out    (cz[0]),
        .quad_out (cq[0])
    );

    // seed each rotation with the inverse gain on the x axis
    for (genvar l = 0; l < LANES; l++) begin : g_seed
        assign cx[0][l] = XW'(CORDIC_GAIN_Q30);
        assign cy[0][l] = '0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_cell
        if (k < NS - 1) begin : g_mid
            e2q_cell #(
                .FRAC_BITS(ANGLE_FRAC_BITS),
                .STAGE    (k)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (cv[k]),
                .in_ready (cr[k]),
                .x_in     (cx[k]),
                .y_in     (cy[k]),
                .z_in     (cz[k]),
                .quad_in  (cq[k]),
                .out_valid(cv[k+1]),
                .out_ready(cr[k+1]),
                .x_out    (cx[k+1]),
                .y_out    (cy[k+1]),
                .z_out    (cz[k+1]),
                .quad_out (cq[k+1])
            );
        end else begin : g_last
            e2q_cell #(
                .FRAC_BITS(ANGLE_FRAC_BITS),
                .STAGE    (k)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (cv[k]),
                .in_ready (cr[k]),
                .x_in     (cx[k]),
                .y_in     (cy[k]),
                .z_in     (cz[k]),
                .quad_in  (cq[k]),
                .out_valid(cv[k+1]),
                .out_ready(cr[k+1]),
                .x_out    (cx[k+1]),
                .y_out    (cy[k+1]),
                .z_out    (),
                .quad_out (cq[k+1])
            );
        end
    end

    e2q_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cv[NS]),
        .in_ready (cr[NS]),
        .x_in     (cx[NS]),
        .y_in     (cy[NS]),
        .quad_in  (cq[NS]),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .quat_w   (m_quat_w),
        .quat_x   (m_quat_x),
        .quat_y   (m_quat_y),
        .quat_z   (m_quat_z)
    );

endmodule

/* sv/e2q_reduce.sv */
module e2q_reduce #(
    parameter int FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] phi,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] theta,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] psi,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [e2q_pkg::z_width(FRAC_BITS)-1:0] z_out [e2q_pkg::LANES],
    output e2q_pkg::quad_t quad_out [e2q_pkg::LANES]
);
    import e2q_pkg::*;

    localparam int ZW = z_width(FRAC_BITS);
    localparam longint QUARTER = QUARTER_DEG << (FRAC_BITS + 1);
    localparam longint CIRCLE = 4 * QUARTER;
    localparam longint SPAN = longint'(1) << ANGLE_W;
    localparam longint OFFSET = ((SPAN + CIRCLE - 1) / CIRCLE) * CIRCLE;
    localparam int UW = $clog2(SPAN + OFFSET);
    localparam int SHIFT = 2 * UW;
    localparam longint RECIP = (longint'(1) << SHIFT) / QUARTER;
    localparam int MW = $clog2(RECIP + 1);
    localparam int PW = UW + MW;
    localparam int QW = $clog2((SPAN + OFFSET) / QUARTER + 1);
    localparam int FW = $clog2(QUARTER);
    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] rdy;

    logic signed [UW:0] a_next [LANES];
    logic [UW-1:0] u_reg [LANES], u_next [LANES];
    logic [PW-1:0] prod [LANES];
    logic [UW-1:0] u2_reg [LANES];
    logic [QW-1:0] qe_reg [LANES], qe_next [LANES];
    logic [FW:0] f0_reg [LANES], f0_next [LANES];
    quad_t q0_reg [LANES], q0_next [LANES];
    logic [FW-1:0] f_reg [LANES], f_next [LANES];
    quad_t q1_reg [LANES], q1_next [LANES];
    logic signed [ZW-1:0] z_reg [LANES], z_next [LANES];
    quad_t q2_reg [LANES];

    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    always_comb begin
        a_next[LANE_A] = (UW+1)'(phi) + (UW+1)'(psi);
        a_next[LANE_B] = (UW+1)'(phi) - (UW+1)'(psi);
        a_next[LANE_T] = (UW+1)'(theta);
        for (int l = 0; l < LANES; l++) begin
            // lift by whole turns so the angle is never negative
            u_next[l] = UW'(a_next[l] + (UW+1)'(OFFSET));
            // quotient by a quarter turn, low by at most one
            prod[l] = PW'(u_reg[l]) * PW'(RECIP);
            qe_next[l] = QW'(prod[l] >> SHIFT);
            f0_next[l] = (FW+1)'(u2_reg[l] - UW'(qe_reg[l]) * UW'(QUARTER));
            q0_next[l] = qe_reg[l][1:0];
            if (f0_reg[l] >= (FW+1)'(QUARTER)) begin
                f_next[l] = FW'(f0_reg[l] - (FW+1)'(QUARTER));
                q1_next[l] = q0_reg[l] + 2'd1;
            end else begin
                f_next[l] = FW'(f0_reg[l]);
                q1_next[l] = q0_reg[l];
            end
            z_next[l] = ZW'(longint'(f_reg[l]) * PI_Q30);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int l = 0; l < LANES; l++) begin
            if (rdy[0]) begin
                u_reg[l] <= u_next[l];
            end
            if (rdy[1]) begin
                u2_reg[l] <= u_reg[l];
                qe_reg[l] <= qe_next[l];
            end
            if (rdy[2]) begin
                f0_reg[l] <= f0_next[l];
                q0_reg[l] <= q0_next[l];
            end
            if (rdy[3]) begin
                f_reg[l] <= f_next[l];
                q1_reg[l] <= q1_next[l];
            end
            if (rdy[4]) begin
                z_reg[l] <= z_next[l];
                q2_reg[l] <= q1_reg[l];
            end
        end
    end

    assign z_out = z_reg;
    assign quad_out = q2_reg;

endmodule

/* sv/e2q_cell.sv */
module e2q_cell #(
    parameter int FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int STAGE = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [e2q_pkg::XW-1:0] x_in [e2q_pkg::LANES],
    input  logic signed [e2q_pkg::XW-1:0] y_in [e2q_pkg::LANES],
    input  logic signed [e2q_pkg::z_width(FRAC_BITS)-1:0] z_in [e2q_pkg::LANES],
    input  e2q_pkg::quad_t quad_in [e2q_pkg::LANES],
    output logic out_valid,
    input  logic out_ready,
    output logic signed [e2q_pkg::XW-1:0] x_out [e2q_pkg::LANES],
    output logic signed [e2q_pkg::XW-1:0] y_out [e2q_pkg::LANES],
    output logic signed [e2q_pkg::z_width(FRAC_BITS)-1:0] z_out [e2q_pkg::LANES],
    output e2q_pkg::quad_t quad_out [e2q_pkg::LANES]
);
    import e2q_pkg::*;

    localparam int ZW = z_width(FRAC_BITS);
    // arctangent in the same scale as the residual angle
    localparam longint ATAN_SCALED = ATAN_Q30[STAGE] * (HALF_CIRCLE_DEG << (FRAC_BITS + 1));

    logic valid_reg;
    logic signed [XW-1:0] x_reg [LANES], x_next [LANES];
    logic signed [XW-1:0] y_reg [LANES], y_next [LANES];
    logic signed [ZW-1:0] z_reg [LANES], z_next [LANES];
    quad_t q_reg [LANES];

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (!z_in[l][ZW-1]) begin
                x_next[l] = x_in[l] - (y_in[l] >>> STAGE);
                y_next[l] = y_in[l] + (x_in[l] >>> STAGE);
                z_next[l] = z_in[l] - ZW'(ATAN_SCALED);
            end else begin
                x_next[l] = x_in[l] + (y_in[l] >>> STAGE);
                y_next[l] = y_in[l] - (x_in[l] >>> STAGE);
                z_next[l] = z_in[l] + ZW'(ATAN_SCALED);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            for (int l = 0; l < LANES; l++) begin
                x_reg[l] <= x_next[l];
                y_reg[l] <= y_next[l];
                z_reg[l] <= z_next[l];
                q_reg[l] <= quad_in[l];
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign quad_out = q_reg;

endmodule

/* sv/e2q_out.sv */
module e2q_out (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [e2q_pkg::XW-1:0] x_in [e2q_pkg::LANES],
    input  logic signed [e2q_pkg::XW-1:0] y_in [e2q_pkg::LANES],
    input  e2q_pkg::quad_t quad_in [e2q_pkg::LANES],
    output logic out_valid,
    input  logic out_ready,
    output logic signed [e2q_pkg::QUAT_W-1:0] quat_w,
    output logic signed [e2q_pkg::QUAT_W-1:0] quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0] quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0] quat_z
);
    import e2q_pkg::*;

    localparam int PW = 2 * XW;
    localparam int DROP = 2 * CORDIC_FRAC - QUAT_FRAC;
    localparam int SW = PW - DROP;
    localparam int PARTS = 4;
    localparam int PART_W = 0;
    localparam int PART_X = 1;
    localparam int PART_Y = 2;
    localparam int PART_Z = 3;
    localparam int STAGES = 2;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] rdy;

    logic signed [XW-1:0] cos_sel [LANES];
    logic signed [XW-1:0] sin_sel [LANES];
    logic signed [PW-1:0] p_reg [PARTS], p_next [PARTS];
    logic signed [PW-1:0] rnd [PARTS];
    logic signed [SW-1:0] sh [PARTS];
    logic signed [QUAT_W-1:0] q_reg [PARTS], q_next [PARTS];

    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        rdy[0] = !valid_reg[0] || rdy[1];
    end

    assign in_ready = rdy[0];
    assign out_valid = valid_reg[STAGES-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            case (quad_in[l])
                QUAD_0: begin
                    cos_sel[l] = x_in[l];
                    sin_sel[l] = y_in[l];
                end
                QUAD_1: begin
                    cos_sel[l] = -y_in[l];
                    sin_sel[l] = x_in[l];
                end
                QUAD_2: begin
                    cos_sel[l] = -x_in[l];
                    sin_sel[l] = -y_in[l];
                end
                default: begin
                    // fourth quadrant
                    cos_sel[l] = y_in[l];
                    sin_sel[l] = -x_in[l];
                end
            endcase
        end
        p_next[PART_W] = PW'(cos_sel[LANE_A]) * PW'(cos_sel[LANE_T]);
        p_next[PART_X] = PW'(cos_sel[LANE_B]) * PW'(sin_sel[LANE_T]);
        p_next[PART_Y] = PW'(sin_sel[LANE_B]) * PW'(sin_sel[LANE_T]);
        p_next[PART_Z] = PW'(sin_sel[LANE_A]) * PW'(cos_sel[LANE_T]);
        for (int k = 0; k < PARTS; k++) begin
            // round to nearest, then clamp to Q1.15
            rnd[k] = p_reg[k] + (PW'(1) <<< (DROP - 1));
            sh[k] = SW'(rnd[k] >>> DROP);
            if (sh[k] > SW'(QUAT_MAX)) begin
                q_next[k] = QUAT_W'(QUAT_MAX);
            end else if (sh[k] < SW'(QUAT_MIN)) begin
                q_next[k] = QUAT_W'(QUAT_MIN);
            end else begin
                q_next[k] = QUAT_W'(sh[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (rdy[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < PARTS; k++) begin
            if (rdy[0]) begin
                p_reg[k] <= p_next[k];
            end
            if (rdy[1]) begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign quat_w = q_reg[PART_W];
    assign quat_x = q_reg[PART_X];
    assign quat_y = q_reg[PART_Y];
    assign quat_z = q_reg[PART_Z];

endmodule
